// File: sv/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside of reset.
`define UPP_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Checks a property at every rising clock edge, reset included.
`define UPP_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

// File: sv/upp_pkg.sv
package upp_pkg;

   localparam int CORDIC_STAGES    = 16;
   localparam int ANGLE_TABLE_SIZE = 24;
   localparam int STAGE_IDX_W      = $clog2(ANGLE_TABLE_SIZE);

   localparam logic [15:0]        TIME_STEP_RESET = 16'd6554;
   localparam logic signed [31:0] GAIN_INV_Q30    = 32'sd652032874;
   localparam logic signed [63:0] DISP_ROUND      = 64'sd137438953472;
   localparam logic signed [40:0] TURN_ROUND      = 41'sd8388608;

   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
   } rot_type;

   typedef struct packed {
      logic signed [31:0] x_pos;
      logic signed [31:0] y_pos;
      logic signed [31:0] travel;
      logic [15:0]        head;
      logic               flip;
   } side_type;

   typedef struct packed {
      rot_type  rot;
      side_type side;
   } cell_type;

   typedef struct packed {
      logic signed [31:0] new_x;
      logic signed [31:0] new_y;
      logic [15:0]        new_heading;
   } result_type;

   function automatic logic signed [31:0] atan_turns(input logic [STAGE_IDX_W-1:0] idx);
      logic signed [31:0] r;
      unique case (idx)
         5'd0:  r = 32'sh20000000;
         5'd1:  r = 32'sh12E4051E;
         5'd2:  r = 32'sh09FB385B;
         5'd3:  r = 32'sh051111D4;
         5'd4:  r = 32'sh028B0D43;
         5'd5:  r = 32'sh0145D7E1;
         5'd6:  r = 32'sh00A2F61E;
         5'd7:  r = 32'sh00517C55;
         5'd8:  r = 32'sh0028BE53;
         5'd9:  r = 32'sh00145F2F;
         5'd10: r = 32'sh000A2F98;
         5'd11: r = 32'sh000517CC;
         5'd12: r = 32'sh00028BE6;
         5'd13: r = 32'sh000145F3;
         5'd14: r = 32'sh0000A2FA;
         5'd15: r = 32'sh0000517D;
         5'd16: r = 32'sh000028BE;
         5'd17: r = 32'sh0000145F;
         5'd18: r = 32'sh00000A30;
         5'd19: r = 32'sh00000518;
         5'd20: r = 32'sh0000028C;
         5'd21: r = 32'sh00000146;
         5'd22: r = 32'sh000000A3;
         5'd23: r = 32'sh00000051;
         default: r = 32'sh00000000;
      endcase
      return r;
   endfunction

endpackage

// File: sv/unicycle_pose_integrator.sv
// Path: a beat passes the prep, CORDIC_STAGES cell, disp and output registers in order.
// Throughput: one beat per cycle unless stalled; each CORDIC cell handles one rotation step.
// A one-entry skid register behind the output register absorbs a stalled result.
// Reset clears all valid flags and restores time_step to 6554; payload is not reset.
module unicycle_pose_integrator (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic signed [31:0]  req_x_position,
   input  logic signed [31:0]  req_y_position,
   input  logic [15:0]         req_heading,
   input  logic signed [23:0]  req_linear_speed,
   input  logic signed [23:0]  req_turn_rate,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic signed [31:0]  rsp_new_x,
   output logic signed [31:0]  rsp_new_y,
   output logic [15:0]         rsp_new_heading,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [15:0]         csr_time_step
);

   `include "assert_macros.svh"

   localparam int N = upp_pkg::CORDIC_STAGES;

   logic                  enable;
   logic [15:0]           time_step_ff;
   logic                  chain_valid [N+1];
   upp_pkg::cell_type     chain_data  [N+1];
   logic                  res_valid;
   upp_pkg::result_type   res_data;
   logic                  incoming;
   logic                  pop;
   logic                  rsp_valid_ff;
   upp_pkg::result_type   rsp_data_ff;
   logic                  skid_valid_ff;
   upp_pkg::result_type   skid_data_ff;

   assign enable    = !skid_valid_ff;
   assign req_stall = skid_valid_ff;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         time_step_ff <= upp_pkg::TIME_STEP_RESET;
      end else if (csr_valid && csr_ready) begin
         time_step_ff <= csr_time_step;
      end
   end

   upp_prep u_prep (
      .clock        (clock),
      .reset        (reset),
      .enable       (enable),
      .valid_in     (req_valid),
      .x_position   (req_x_position),
      .y_position   (req_y_position),
      .heading      (req_heading),
      .linear_speed (req_linear_speed),
      .turn_rate    (req_turn_rate),
      .time_step    (time_step_ff),
      .valid_ff     (chain_valid[0]),
      .data_ff      (chain_data[0])
   );

   for (genvar i = 0; i < N; i++) begin : g_cell
      upp_cordic_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .enable      (enable),
         .stage_index (upp_pkg::STAGE_IDX_W'(i)),
         .valid_in    (chain_valid[i]),
         .data_in     (chain_data[i]),
         .valid_ff    (chain_valid[i+1]),
         .data_ff     (chain_data[i+1])
      );
   end

   upp_disp u_disp (
      .clock    (clock),
      .reset    (reset),
      .enable   (enable),
      .valid_in (chain_valid[N]),
      .data_in  (chain_data[N]),
      .valid_ff (res_valid),
      .result   (res_data)
   );

   assign incoming = enable && res_valid;
   assign pop      = rsp_valid_ff && !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (pop || !rsp_valid_ff) begin
         rsp_valid_ff  <= skid_valid_ff || incoming;
         skid_valid_ff <= 1'b0;
      end else if (incoming) begin
         skid_valid_ff <= 1'b1;
      end
      if (pop || !rsp_valid_ff) begin
         rsp_data_ff <= skid_valid_ff ? skid_data_ff : res_data;
      end else if (incoming) begin
         skid_data_ff <= res_data;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_new_x       = rsp_data_ff.new_x;
   assign rsp_new_y       = rsp_data_ff.new_y;
   assign rsp_new_heading = rsp_data_ff.new_heading;

   `UPP_ASSERT(a_skid_needs_out, skid_valid_ff |-> rsp_valid_ff, "skid holds a beat with no output beat")
   `UPP_ASSERT(a_skid_fill, (skid_valid_ff && !$past(skid_valid_ff)) |-> $past(rsp_valid_ff && rsp_stall), "skid filled without a stalled output")
   `UPP_ASSERT(a_csr_write, (csr_valid && csr_ready) |=> (time_step_ff == $past(csr_time_step)), "time_step not updated by a write")

endmodule

// File: sv/upp_prep.sv
module upp_prep (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   enable,
   input  logic                   valid_in,
   input  logic signed [31:0]     x_position,
   input  logic signed [31:0]     y_position,
   input  logic [15:0]            heading,
   input  logic signed [23:0]     linear_speed,
   input  logic signed [23:0]     turn_rate,
   input  logic [15:0]            time_step,
   output logic                   valid_ff,
   output upp_pkg::cell_type      data_ff
);

   logic                 valid_in_d;
   upp_pkg::cell_type    data_in;
   logic signed [40:0]   dist_prod;
   logic signed [40:0]   turn_prod;
   logic signed [40:0]   turn_rnd;
   logic [15:0]          folded;

   always_comb begin
      dist_prod = 41'(linear_speed) * 41'($signed({1'b0, time_step}));
      turn_prod = 41'(turn_rate) * 41'($signed({1'b0, time_step}));
      turn_rnd  = turn_prod + upp_pkg::TURN_ROUND;

      data_in.side.flip   = heading[15] ^ heading[14];
      folded              = heading ^ {data_in.side.flip, 15'd0};
      data_in.side.x_pos  = x_position;
      data_in.side.y_pos  = y_position;
      data_in.side.travel = dist_prod[39:8];
      data_in.side.head   = heading + turn_rnd[39:24];
      data_in.rot.x       = upp_pkg::GAIN_INV_Q30;
      data_in.rot.y       = 32'sd0;
      data_in.rot.z       = $signed({folded, 16'd0});
      valid_in_d          = valid_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= valid_in_d;
      end
      if (enable) begin
         data_ff <= data_in;
      end
   end

endmodule

// File: sv/upp_cordic_cell.sv
module upp_cordic_cell (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                enable,
   input  logic [upp_pkg::STAGE_IDX_W-1:0]     stage_index,
   input  logic                                valid_in,
   input  upp_pkg::cell_type                   data_in,
   output logic                                valid_ff,
   output upp_pkg::cell_type                   data_ff
);

   upp_pkg::cell_type  data_next;
   logic signed [31:0] x_shift;
   logic signed [31:0] y_shift;
   logic signed [31:0] angle;

   always_comb begin
      x_shift   = data_in.rot.x >>> stage_index;
      y_shift   = data_in.rot.y >>> stage_index;
      angle     = upp_pkg::atan_turns(stage_index);
      data_next = data_in;
      if (!data_in.rot.z[31]) begin
         data_next.rot.x = data_in.rot.x - y_shift;
         data_next.rot.y = data_in.rot.y + x_shift;
         data_next.rot.z = data_in.rot.z - angle;
      end else begin
         data_next.rot.x = data_in.rot.x + y_shift;
         data_next.rot.y = data_in.rot.y - x_shift;
         data_next.rot.z = data_in.rot.z + angle;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= valid_in;
      end
      if (enable) begin
         data_ff <= data_next;
      end
   end

endmodule

// File: sv/upp_disp.sv
module upp_disp (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  enable,
   input  logic                  valid_in,
   input  upp_pkg::cell_type     data_in,
   output logic                  valid_ff,
   output upp_pkg::result_type   result
);

   logic signed [31:0] cos_val;
   logic signed [31:0] sin_val;
   logic signed [63:0] prod_x_in;
   logic signed [63:0] prod_y_in;
   logic signed [63:0] prod_x_ff;
   logic signed [63:0] prod_y_ff;
   logic signed [31:0] x_pos_ff;
   logic signed [31:0] y_pos_ff;
   logic [15:0]        head_ff;
   logic signed [63:0] rnd_x;
   logic signed [63:0] rnd_y;
   logic signed [32:0] sum_x;
   logic signed [32:0] sum_y;

   always_comb begin
      cos_val   = data_in.side.flip ? -data_in.rot.x : data_in.rot.x;
      sin_val   = data_in.side.flip ? -data_in.rot.y : data_in.rot.y;
      prod_x_in = 64'(data_in.side.travel) * 64'(cos_val);
      prod_y_in = 64'(data_in.side.travel) * 64'(sin_val);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= valid_in;
      end
      if (enable) begin
         prod_x_ff <= prod_x_in;
         prod_y_ff <= prod_y_in;
         x_pos_ff  <= data_in.side.x_pos;
         y_pos_ff  <= data_in.side.y_pos;
         head_ff   <= data_in.side.head;
      end
   end

   always_comb begin
      rnd_x = prod_x_ff + upp_pkg::DISP_ROUND;
      rnd_y = prod_y_ff + upp_pkg::DISP_ROUND;
      sum_x = 33'(x_pos_ff) + 33'($signed(rnd_x[63:38]));
      sum_y = 33'(y_pos_ff) + 33'($signed(rnd_y[63:38]));

      if (sum_x[32] != sum_x[31]) begin
         result.new_x = sum_x[32] ? 32'sh80000000 : 32'sh7FFFFFFF;
      end else begin
         result.new_x = sum_x[31:0];
      end
      if (sum_y[32] != sum_y[31]) begin
         result.new_y = sum_y[32] ? 32'sh80000000 : 32'sh7FFFFFFF;
      end else begin
         result.new_y = sum_y[31:0];
      end
      result.new_heading = head_ff;
   end

endmodule
